// ----- rtl/core/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// Used by the allocator core and by its port checker; depends on nothing.
package ffha_pkg;

	localparam int ADDR_W = 14;
	localparam int STAT_W = 2;
	localparam int HEAP_WORDS_DEF = 4096;

	// operation codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
		logic [ADDR_W-1:0] stack_limit;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [STAT_W-1:0] status;
	} rsp_t;

endpackage

// ----- rtl/core/first_fit_heap_allocator_core.sv -----
// First-fit heap allocator core: sequencer over one word memory of the heap.
// Depends on ffha_pkg.
//
//  channel   direction  handshake                       word
//  request   in         start high, busy low at edge    req  (req_t)
//  result    out        done high for one cycle         rsp  (rsp_t)
//  config    in         cfg_we high at edge             cfg_data (pool base)
//
// One request is in work at a time; a memory read is registered and returns
// its data the cycle after, so the free-list walk sets the time. A release
// walks the free list to its insertion point, then checks, links and merges.
// An allocate visits free slots for the fit; a grow adds a release and a
// second search. A null or zero-size request, or one that cannot fit at all,
// answers the cycle after it is accepted. Reset or a pool_base write passes
// through S_INIT, writing the first header, busy high. Results cannot be
// stalled.
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int XW = AW + ADDR_W;
	localparam int SW = $clog2(HEAP_WORDS + 1);
	localparam int LW = ADDR_W + 1;
	localparam int NW = ADDR_W + 2;
	localparam logic [ADDR_W-1:0] HDR_OFS = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] AMAX = {ADDR_W{1'b1}};

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_INIT  = 5'd1;
	localparam logic [4:0] S_SRCH  = 5'd2;
	localparam logic [4:0] S_HDR   = 5'd3;
	localparam logic [4:0] S_NEXT  = 5'd4;
	localparam logic [4:0] S_SP2   = 5'd5;
	localparam logic [4:0] S_SP3   = 5'd6;
	localparam logic [4:0] S_SP4   = 5'd7;
	localparam logic [4:0] S_SP5   = 5'd8;
	localparam logic [4:0] S_UL0   = 5'd9;
	localparam logic [4:0] S_UL1   = 5'd10;
	localparam logic [4:0] S_G1    = 5'd11;
	localparam logic [4:0] S_G2    = 5'd12;
	localparam logic [4:0] S_RWALK = 5'd13;
	localparam logic [4:0] S_RWD   = 5'd14;
	localparam logic [4:0] S_RCK1  = 5'd15;
	localparam logic [4:0] S_RCK2  = 5'd16;
	localparam logic [4:0] S_RW2   = 5'd17;
	localparam logic [4:0] S_MA1   = 5'd18;
	localparam logic [4:0] S_MA2   = 5'd19;
	localparam logic [4:0] S_MA3   = 5'd20;
	localparam logic [4:0] S_MA4   = 5'd21;
	localparam logic [4:0] S_MA5   = 5'd22;
	localparam logic [4:0] S_MB0   = 5'd24;
	localparam logic [4:0] S_MB1   = 5'd25;
	localparam logic [4:0] S_MB2   = 5'd26;
	localparam logic [4:0] S_MB3   = 5'd27;
	localparam logic [4:0] S_REND  = 5'd28;

	// control registers
	logic [4:0]        state_q, state_d;
	logic [ADDR_W-1:0] last_q, last_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [SW-1:0]     steps_q, steps_d;
	logic              pass_q, pass_d;
	logic              grow_q, grow_d;
	logic              done_q, done_d;
	// working registers
	logic [ADDR_W-1:0] p_q, p_d;
	logic [ADDR_W-1:0] before_q, before_d;
	logic [ADDR_W-1:0] after_q, after_d;
	logic [ADDR_W-1:0] cur_q, cur_d;
	logic [ADDR_W-1:0] sp_q, sp_d;
	logic [ADDR_W-1:0] nl_q, nl_d;
	logic [ADDR_W-1:0] ns_q, ns_d;
	logic [ADDR_W-1:0] hp_q, hp_d;
	logic [LW-1:0]     len_q, len_d;
	logic [STAT_W-1:0] st_q, st_d;
	rsp_t              rsp_q, rsp_d;

	// memory port
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_addr, mem_wdata;
	logic [XW-1:0]     mem_wix;
	logic              mem_inr;
	logic [ADDR_W-1:0] heap_mem [HEAP_WORDS];
	logic [ADDR_W-1:0] rd_q;
	logic              rd_oor_q;
	logic [ADDR_W-1:0] rdat;

	// scratch
	logic [LW-1:0] len_c, lsum_c, base_c;
	logic [NW-1:0] ns_c, nl_c;
	logic          bad_c;

	assign mem_wix = XW'(mem_addr[ADDR_W-1:2]);
	assign mem_inr = mem_wix < XW'(HEAP_WORDS);
	assign rdat    = rd_oor_q ? '0 : rd_q;

	// heap memory: one access a cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we && mem_inr) begin
			heap_mem[mem_wix[AW-1:0]] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q     <= heap_mem[mem_wix[AW-1:0]];
			rd_oor_q <= !mem_inr;
		end
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		last_d   = last_q;
		head_d   = head_q;
		steps_d  = steps_q;
		pass_d   = pass_q;
		grow_d   = grow_q;
		done_d   = 1'b0;
		p_d      = p_q;
		before_d = before_q;
		after_d  = after_q;
		cur_d    = cur_q;
		sp_d     = sp_q;
		nl_d     = nl_q;
		ns_d     = ns_q;
		hp_d     = hp_q;
		len_d    = len_q;
		st_d     = st_q;
		rsp_d    = rsp_q;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		len_c  = ({1'b0, req.request_size} + LW'(3)) & ~LW'(3);
		lsum_c = {1'b0, last_q} + len_c;
		base_c = ({1'b0, cfg_data} + LW'(3)) & ~LW'(3);
		ns_c   = NW'(cur_q) + NW'(4) + NW'(len_q);
		nl_c   = NW'(last_q) + NW'(4) + NW'(len_q);
		bad_c  = (after_q == p_q) || (hp_q <= p_q) ||
			((after_q != '0) && (hp_q > after_q)) ||
			((before_q != '0) && (rdat > p_q));

		if (cfg_we) begin
			// reinitialize the heap at the new base
			last_d  = base_c[ADDR_W-1:0] + HDR_OFS;
			head_d  = '0;
			state_d = S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					mem_we   = 1'b1;
					mem_addr = last_q - HDR_OFS;
					state_d  = S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						st_d   = ST_OK;
						sp_d   = req.stack_limit;
						len_d  = len_c;
						grow_d = 1'b0;
						pass_d = 1'b0;
						if (req.operation == OP_RELEASE) begin
							if (req.block_address == '0) begin
								done_d  = 1'b1;
								rsp_d   = '{result_address: '0, status: ST_OK};
							end else begin
								p_d      = req.block_address;
								before_d = '0;
								after_d  = head_q;
								steps_d  = '0;
								state_d  = S_RWALK;
							end
						end else if (req.request_size == '0) begin
							done_d = 1'b1;
							rsp_d  = '{result_address: '0, status: ST_OK};
						end else if (lsum_c > LW'(AMAX)) begin
							done_d = 1'b1;
							rsp_d  = '{result_address: '0, status: ST_OOM};
						end else begin
							before_d = '0;
							cur_d    = head_q;
							steps_d  = '0;
							state_d  = S_SRCH;
						end
					end
				end
				// search: visit one free slot
				S_SRCH: begin
					if (cur_q == '0) begin
						if (!pass_q) begin
							mem_re   = 1'b1;
							mem_addr = last_q - HDR_OFS;
							state_d  = S_G1;
						end else begin
							done_d  = 1'b1;
							rsp_d   = '{result_address: '0, status: st_q};
							state_d = S_IDLE;
						end
					end else if (steps_q == SW'(HEAP_WORDS)) begin
						done_d  = 1'b1;
						rsp_d   = '{result_address: '0, status: ST_BAD};
						state_d = S_IDLE;
					end else begin
						steps_d  = steps_q + SW'(1);
						mem_re   = 1'b1;
						mem_addr = cur_q - HDR_OFS;
						state_d  = S_HDR;
					end
				end
				S_HDR: begin
					ns_d = ns_c[ADDR_W-1:0];
					if (ns_c <= NW'(rdat)) begin
						if (ns_c + NW'(8) <= NW'(rdat)) begin
							mem_we    = 1'b1;
							mem_addr  = ns_c[ADDR_W-1:0] - HDR_OFS;
							mem_wdata = rdat;
							state_d   = S_SP2;
						end else begin
							state_d = S_UL0;
						end
					end else begin
						before_d = cur_q;
						mem_re   = 1'b1;
						mem_addr = cur_q;
						state_d  = S_NEXT;
					end
				end
				S_NEXT: begin
					cur_d   = rdat;
					state_d = S_SRCH;
				end
				// split the fit
				S_SP2: begin
					mem_we    = 1'b1;
					mem_addr  = cur_q - HDR_OFS;
					mem_wdata = ns_q;
					state_d   = S_SP3;
				end
				S_SP3: begin
					mem_re   = 1'b1;
					mem_addr = cur_q;
					state_d  = S_SP4;
				end
				S_SP4: begin
					mem_we    = 1'b1;
					mem_addr  = ns_q;
					mem_wdata = rdat;
					state_d   = S_SP5;
				end
				S_SP5: begin
					mem_we    = 1'b1;
					mem_addr  = cur_q;
					mem_wdata = ns_q;
					state_d   = S_UL0;
				end
				// unlink the taken slot
				S_UL0: begin
					mem_re   = 1'b1;
					mem_addr = cur_q;
					state_d  = S_UL1;
				end
				S_UL1: begin
					if (before_q != '0) begin
						mem_we    = 1'b1;
						mem_addr  = before_q;
						mem_wdata = rdat;
					end else begin
						head_d = rdat;
					end
					done_d  = 1'b1;
					rsp_d   = '{result_address: cur_q, status: st_q};
					state_d = S_IDLE;
				end
				// grow the heap by one slot
				S_G1: begin
					if (rdat != '0) begin
						done_d  = 1'b1;
						rsp_d   = '{result_address: '0, status: ST_BAD};
						state_d = S_IDLE;
					end else if (nl_c > NW'(AMAX) || nl_c >= NW'(sp_q)) begin
						done_d  = 1'b1;
						rsp_d   = '{result_address: '0, status: ST_OOM};
						state_d = S_IDLE;
					end else begin
						nl_d      = nl_c[ADDR_W-1:0];
						mem_we    = 1'b1;
						mem_addr  = last_q - HDR_OFS;
						mem_wdata = nl_c[ADDR_W-1:0];
						state_d   = S_G2;
					end
				end
				// close the new end, then release the old last slot unless null
				S_G2: begin
					mem_we   = 1'b1;
					mem_addr = nl_q - HDR_OFS;
					grow_d   = 1'b1;
					p_d      = last_q;
					before_d = '0;
					after_d  = head_q;
					steps_d  = '0;
					state_d  = (last_q == '0) ? S_REND : S_RWALK;
				end
				// release: walk to the insertion point
				S_RWALK: begin
					if (after_q != '0 && p_q > after_q) begin
						if (steps_q == SW'(HEAP_WORDS)) begin
							st_d    = ST_BAD;
							state_d = S_REND;
						end else begin
							steps_d  = steps_q + SW'(1);
							before_d = after_q;
							mem_re   = 1'b1;
							mem_addr = after_q;
							state_d  = S_RWD;
						end
					end else begin
						mem_re   = 1'b1;
						mem_addr = p_q - HDR_OFS;
						state_d  = S_RCK1;
					end
				end
				S_RWD: begin
					after_d = rdat;
					state_d = S_RWALK;
				end
				S_RCK1: begin
					hp_d     = rdat;
					mem_re   = 1'b1;
					mem_addr = before_q - HDR_OFS;
					state_d  = S_RCK2;
				end
				S_RCK2: begin
					if (bad_c) begin
						st_d    = ST_BAD;
						state_d = S_REND;
					end else begin
						mem_we    = 1'b1;
						mem_addr  = p_q;
						mem_wdata = after_q;
						state_d   = S_RW2;
					end
				end
				S_RW2: begin
					if (before_q != '0) begin
						mem_we    = 1'b1;
						mem_addr  = before_q;
						mem_wdata = p_q;
					end else begin
						head_d = p_q;
					end
					state_d = (after_q != '0) ? S_MA1 : S_MB0;
				end
				// merge with the following free slot
				S_MA1: begin
					mem_re   = 1'b1;
					mem_addr = p_q - HDR_OFS;
					state_d  = S_MA2;
				end
				S_MA2: begin
					if (rdat == after_q) begin
						mem_re   = 1'b1;
						mem_addr = after_q - HDR_OFS;
						state_d  = S_MA3;
					end else begin
						state_d = S_MB0;
					end
				end
				S_MA3: begin
					mem_we    = 1'b1;
					mem_addr  = p_q - HDR_OFS;
					mem_wdata = rdat;
					state_d   = S_MA4;
				end
				S_MA4: begin
					mem_re   = 1'b1;
					mem_addr = after_q;
					state_d  = S_MA5;
				end
				// take over the link of the absorbed slot
				S_MA5: begin
					mem_we    = 1'b1;
					mem_addr  = p_q;
					mem_wdata = rdat;
					after_d   = rdat;
					state_d   = S_MB0;
				end
				// merge with the preceding free slot
				S_MB0: begin
					mem_re   = (before_q != '0);
					mem_addr = before_q - HDR_OFS;
					state_d  = (before_q != '0) ? S_MB1 : S_REND;
				end
				S_MB1: begin
					if (rdat == p_q) begin
						mem_re   = 1'b1;
						mem_addr = p_q - HDR_OFS;
						state_d  = S_MB2;
					end else begin
						state_d = S_REND;
					end
				end
				S_MB2: begin
					mem_we    = 1'b1;
					mem_addr  = before_q - HDR_OFS;
					mem_wdata = rdat;
					state_d   = S_MB3;
				end
				S_MB3: begin
					mem_we    = 1'b1;
					mem_addr  = before_q;
					mem_wdata = after_q;
					state_d   = S_REND;
				end
				S_REND: begin
					if (grow_q) begin
						last_d   = nl_q;
						grow_d   = 1'b0;
						pass_d   = 1'b1;
						before_d = '0;
						cur_d    = head_q;
						steps_d  = '0;
						state_d  = S_SRCH;
					end else begin
						done_d  = 1'b1;
						rsp_d   = '{result_address: '0, status: st_q};
						state_d = S_IDLE;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			last_q  <= HDR_OFS;
			head_q  <= '0;
			steps_q <= '0;
			pass_q  <= 1'b0;
			grow_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			head_q  <= head_d;
			steps_q <= steps_d;
			pass_q  <= pass_d;
			grow_q  <= grow_d;
			done_q  <= done_d;
		end
	end

	// hold working values
	always_ff @(posedge clk) begin
		p_q      <= p_d;
		before_q <= before_d;
		after_q  <= after_d;
		cur_q    <= cur_d;
		sp_q     <= sp_d;
		nl_q     <= nl_d;
		ns_q     <= ns_d;
		hp_q     <= hp_d;
		len_q    <= len_d;
		st_q     <= st_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/core/ffha_checker.sv -----
// Port checker for the first-fit heap allocator core, bound to its top level.
// Depends on ffha_pkg.
module ffha_port_props
	import ffha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// handshake outputs are always known
	a_no_x: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({busy, done}))
		else $error("unknown handshake output");

	// the result goes out as the block turns idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// an accepted request occupies the block
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request dropped");

	// an out-of-memory answer never returns an address
	a_oom_null: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OOM) |-> (rsp.result_address == '0))
		else $error("address returned with out-of-memory status");

endmodule

bind first_fit_heap_allocator_core ffha_port_props u_ffha_port_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
